### hw/rtl/circle_wall_bounce_and_integrate_macros.svh
// Assertion macros shared by the circle bounce and integrate RTL.
`ifndef CIRCLE_WALL_BOUNCE_AND_INTEGRATE_MACROS_SVH
`define CIRCLE_WALL_BOUNCE_AND_INTEGRATE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only out of reset.
`define CWB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Checked at every edge, reset included.
`define CWB_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define CWB_ASSERT(name, prop, msg)
`define CWB_ASSERT_RST(name, prop, msg)
`endif

`endif

### hw/rtl/cwbi_pkg.sv
// Package for the circle bounce and integrate block: words, register codes, widths.
package cwbi_pkg;

  localparam int FracBitsDef = 16;
  localparam int VelW        = 33;  // 32 bit velocity plus room for one negation
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 21;

  localparam logic [CfgIdxW-1:0] CfgFieldWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFieldHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeStep    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGravity     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDrag        = 3'd4;

  localparam logic [15:0] FieldWidthRst  = 16'd640;
  localparam logic [15:0] FieldHeightRst = 16'd480;
  localparam logic [19:0] TimeStepRst    = 20'd65536;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [14:0] radius;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } out_word_t;

  function automatic int max_i(input int a, input int b);
    max_i = (a > b) ? a : b;
  endfunction

  // Position after the walls: input range or wall range, whichever is wider.
  function automatic int pos_w(input int frac);
    pos_w = max_i(32, 17 + frac) + 2;
  endfunction

  // Half gravity step dt*g/2 in fixed point.
  function automatic int hg_w(input int frac);
    hg_w = 41 - frac;
  endfunction

  // Half-step velocity vy + h and vy + 2h.
  function automatic int iv_w(input int frac);
    iv_w = max_i(VelW, hg_w(frac)) + 2;
  endfunction

endpackage

### hw/rtl/cwbi_wall.sv
// Four-stage wall clamp: right, left, floor (with damping) and top walls.
`include "circle_wall_bounce_and_integrate_macros.svh"

module cwbi_wall #(
  parameter int FRAC_BITS = cwbi_pkg::FracBitsDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic [15:0]                                  field_width_i,
  input  logic [15:0]                                  field_height_i,
  input  logic                                         gpos_i,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  cwbi_pkg::in_word_t                           in_word_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic signed [cwbi_pkg::pos_w(FRAC_BITS)-1:0] px_o,
  output logic signed [cwbi_pkg::pos_w(FRAC_BITS)-1:0] py_o,
  output logic signed [cwbi_pkg::VelW-1:0]             vx_o,
  output logic signed [cwbi_pkg::VelW-1:0]             vy_o
);

  localparam int F     = FRAC_BITS;
  localparam int PosW  = cwbi_pkg::pos_w(F);
  localparam int VelW  = cwbi_pkg::VelW;
  localparam int DmpW  = F + 4;
  localparam int ProdW = DmpW + F + 1;
  localparam int RndW  = ProdW + 1 - F;

  localparam int K05  = ((5 << F) + 50) / 100;
  localparam int K27  = ((27 << F) + 5) / 10;
  localparam int K07  = ((7 << F) + 5) / 10;
  localparam int K047 = ((47 << F) + 50) / 100;

  localparam logic signed [VelW-1:0]  K05V  = VelW'(K05);
  localparam logic signed [VelW-1:0]  K27V  = VelW'(K27);
  localparam logic signed [F:0]       K07S  = (F+1)'(K07);
  localparam logic signed [RndW-1:0]  K047R = RndW'(K047);
  localparam logic signed [ProdW:0]   HalfP = (ProdW+1)'(1) <<< (F - 1);

  function automatic logic signed [VelW-1:0] reflect_dead(input logic signed [VelW-1:0] v);
    reflect_dead = (v < K05V && v > -K05V) ? '0 : -v;
  endfunction

  logic [3:0] v_q;
  logic [4:0] en;

  assign en[4] = out_ready_i;
  for (genvar k = 0; k < 4; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 4; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: right wall on x, floor on y
  logic signed [PosW-1:0] pxe, pye, rfx_in, wfx, hfx, px1_d, py1_d;
  logic signed [VelW-1:0] vxe, vye, vx1_d, vy1_d;
  logic                   hit_r, hit_f, damp1_d;

  assign pxe    = PosW'(in_word_i.pos_x);
  assign pye    = PosW'(in_word_i.pos_y);
  assign vxe    = VelW'(in_word_i.vel_x);
  assign vye    = VelW'(in_word_i.vel_y);
  assign rfx_in = PosW'({in_word_i.radius, {F{1'b0}}});
  assign wfx    = PosW'({field_width_i, {F{1'b0}}});
  assign hfx    = PosW'({field_height_i, {F{1'b0}}});

  assign hit_r   = (pxe + rfx_in) >= wfx;
  assign hit_f   = (pye + rfx_in) >= hfx;
  assign damp1_d = hit_f && gpos_i && (vye < K27V) && (vye > -K27V);
  assign px1_d   = hit_r ? (wfx - rfx_in) : pxe;
  assign vx1_d   = hit_r ? reflect_dead(vxe) : vxe;
  assign py1_d   = hit_f ? (hfx - rfx_in) : pye;
  assign vy1_d   = (hit_f && !damp1_d) ? -vye : vye;

  logic signed [PosW-1:0] px1_q, py1_q;
  logic signed [VelW-1:0] vx1_q, vy1_q;
  logic [14:0]            r1_q;
  logic                   damp1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      px1_q   <= px1_d;
      py1_q   <= py1_d;
      vx1_q   <= vx1_d;
      vy1_q   <= vy1_d;
      r1_q    <= in_word_i.radius;
      damp1_q <= damp1_d;
    end
  end

  // Stage 2: left wall on x, top position on y, floor damping product
  logic signed [PosW-1:0]  rfx1, px2_d, py2_d;
  logic signed [VelW-1:0]  vx2_d;
  logic signed [DmpW-1:0]  dmp_op;
  logic signed [ProdW-1:0] dprod;
  logic                    hit_l, hit_t;

  assign rfx1   = PosW'({r1_q, {F{1'b0}}});
  assign hit_l  = (px1_q - rfx1) <= 0;
  assign hit_t  = (py1_q - rfx1) <= 0;
  assign px2_d  = hit_l ? rfx1 : px1_q;
  assign vx2_d  = hit_l ? reflect_dead(vx1_q) : vx1_q;
  assign py2_d  = hit_t ? rfx1 : py1_q;
  // damped speed is below 2.7, so the low bits hold it whole
  assign dmp_op = -DmpW'($signed(vy1_q[F+2:0]));
  assign dprod  = ProdW'(dmp_op) * ProdW'(K07S);

  logic signed [PosW-1:0]  px2_q, py2_q;
  logic signed [VelW-1:0]  vx2_q, vy2_q;
  logic signed [ProdW-1:0] dprod2_q;
  logic                    damp2_q, hit_t2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      px2_q    <= px2_d;
      py2_q    <= py2_d;
      vx2_q    <= vx2_d;
      vy2_q    <= vy1_q;
      dprod2_q <= dprod;
      damp2_q  <= damp1_q;
      hit_t2_q <= hit_t;
    end
  end

  // Stage 3: round the damped speed, drop it inside the dead band
  logic signed [ProdW:0]  rsum;
  logic signed [RndW-1:0] rnd;
  logic signed [VelW-1:0] vy3_d;

  assign rsum  = (ProdW+1)'(dprod2_q) + HalfP;
  assign rnd   = RndW'(rsum >>> F);
  assign vy3_d = !damp2_q ? vy2_q :
                 ((rnd < K047R && rnd > -K047R) ? '0 : VelW'(rnd));

  logic signed [PosW-1:0] px3_q, py3_q;
  logic signed [VelW-1:0] vx3_q, vy3_q;
  logic                   hit_t3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      px3_q    <= px2_q;
      py3_q    <= py2_q;
      vx3_q    <= vx2_q;
      vy3_q    <= vy3_d;
      hit_t3_q <= hit_t2_q;
    end
  end

  // Stage 4: top wall reflection
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      px_o <= px3_q;
      py_o <= py3_q;
      vx_o <= vx3_q;
      vy_o <= hit_t3_q ? reflect_dead(vy3_q) : vy3_q;
    end
  end

  `CWB_ASSERT(a_damp_needs_gravity, v_q[0] && damp1_q |-> gpos_i, "floor damping without gravity")
  `CWB_ASSERT(a_stage2_holds, v_q[1] && !en[2] |=> v_q[1], "stalled word lost in stage 2")

endmodule

### hw/rtl/cwbi_integ.sv
// Five-stage half-step integrator with drag, rest thresholds and saturation.
`include "circle_wall_bounce_and_integrate_macros.svh"

module cwbi_integ #(
  parameter int FRAC_BITS = cwbi_pkg::FracBitsDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         gpos_i,
  input  logic signed [cwbi_pkg::hg_w(FRAC_BITS)-1:0]  hg_i,
  input  logic [19:0]                                  dt_i,
  input  logic [FRAC_BITS:0]                           keep_i,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic signed [cwbi_pkg::pos_w(FRAC_BITS)-1:0] px_i,
  input  logic signed [cwbi_pkg::pos_w(FRAC_BITS)-1:0] py_i,
  input  logic signed [cwbi_pkg::VelW-1:0]             vx_i,
  input  logic signed [cwbi_pkg::VelW-1:0]             vy_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output cwbi_pkg::out_word_t                          out_word_o
);

  localparam int F    = FRAC_BITS;
  localparam int PosW = cwbi_pkg::pos_w(F);
  localparam int VelW = cwbi_pkg::VelW;
  localparam int IvW  = cwbi_pkg::iv_w(F);
  localparam int PdxW = 21 + VelW;
  localparam int PvxW = F + 2 + VelW;
  localparam int RxW  = PdxW + 1 - F;
  localparam int RvxW = PvxW + 1 - F;
  localparam int PdyW = 21 + IvW;
  localparam int PvyW = F + 2 + IvW;
  localparam int RyW  = PdyW + 1 - F;
  localparam int NvW  = PvyW + 1 - F;
  localparam int NxW  = cwbi_pkg::max_i(PosW, RxW) + 1;
  localparam int NyW  = cwbi_pkg::max_i(PosW, RyW) + 1;
  localparam int P6W  = 2 * F + 3;
  localparam int R6W  = P6W + 1 - F;

  localparam int K01  = ((1 << F) + 5) / 10;
  localparam int K013 = ((13 << F) + 50) / 100;
  localparam int K035 = ((35 << F) + 50) / 100;
  localparam int K06  = ((6 << F) + 5) / 10;

  localparam logic signed [RvxW-1:0] K01X  = RvxW'(K01);
  localparam logic signed [31:0]     K01S  = 32'(K01);
  localparam logic signed [NvW-1:0]  K013Y = NvW'(K013);
  localparam logic signed [NvW-1:0]  K035Y = NvW'(K035);
  localparam logic signed [F:0]      K06S  = (F+1)'(K06);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = 32'(v);
  endfunction

  logic [4:0] v_q;
  logic [5:0] en;

  assign en[5] = out_ready_i;
  for (genvar k = 0; k < 5; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  logic signed [20:0] dts;
  logic signed [F+1:0] keeps;

  assign dts   = $signed({1'b0, dt_i});
  assign keeps = $signed({1'b0, keep_i});

  // Stage 1: half-step velocity, x products
  logic signed [PosW-1:0] px1_q, py1_q;
  logic signed [PdxW-1:0] pdx1_q;
  logic signed [PvxW-1:0] pvx1_q;
  logic signed [IvW-1:0]  vyh1_q, vyhh1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      px1_q   <= px_i;
      py1_q   <= py_i;
      pdx1_q  <= PdxW'(dts) * PdxW'(vx_i);
      pvx1_q  <= PvxW'(keeps) * PvxW'(vx_i);
      vyh1_q  <= IvW'(vy_i) + IvW'(hg_i);
      vyhh1_q <= IvW'(vy_i) + (IvW'(hg_i) <<< 1);
    end
  end

  // Stage 2: y products, round x products
  logic signed [PdxW:0] rxs;
  logic signed [PvxW:0] rvxs;

  assign rxs  = (PdxW+1)'(pdx1_q) + ((PdxW+1)'(1) <<< (F - 1));
  assign rvxs = (PvxW+1)'(pvx1_q) + ((PvxW+1)'(1) <<< (F - 1));

  logic signed [PosW-1:0] px2_q, py2_q;
  logic signed [RxW-1:0]  rx2_q;
  logic signed [RvxW-1:0] rvx2_q;
  logic signed [PdyW-1:0] pdy2_q;
  logic signed [PvyW-1:0] pvy2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      rx2_q  <= RxW'(rxs >>> F);
      rvx2_q <= RvxW'(rvxs >>> F);
      pdy2_q <= PdyW'(dts) * PdyW'(vyh1_q);
      pvy2_q <= PvyW'(keeps) * PvyW'(vyhh1_q);
    end
  end

  // Stage 3: new x, round y products
  logic signed [PdyW:0] rys;
  logic signed [PvyW:0] rvys;

  assign rys  = (PdyW+1)'(pdy2_q) + ((PdyW+1)'(1) <<< (F - 1));
  assign rvys = (PvyW+1)'(pvy2_q) + ((PvyW+1)'(1) <<< (F - 1));

  logic signed [NxW-1:0]  nx3_q;
  logic signed [PosW-1:0] py3_q;
  logic signed [RyW-1:0]  ry3_q;
  logic signed [RvxW-1:0] nvx3_q;
  logic signed [NvW-1:0]  nvy3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      nx3_q  <= NxW'(px2_q) + NxW'(rx2_q);
      py3_q  <= py2_q;
      ry3_q  <= RyW'(rys >>> F);
      nvx3_q <= rvx2_q;
      nvy3_q <= NvW'(rvys >>> F);
    end
  end

  // Stage 4: new y, rest thresholds, slow-down product
  logic              zx, zy, s06;
  logic signed [P6W-1:0] p06;

  assign zx  = gpos_i && (nvx3_q < K01X) && (nvx3_q > -K01X);
  assign zy  = gpos_i && (nvy3_q < K013Y) && (nvy3_q > -K013Y);
  assign s06 = gpos_i && !zy && (nvy3_q < K035Y) && (nvy3_q > -K035Y);
  // only used below 0.35, where the low bits hold the whole value
  assign p06 = P6W'($signed(nvy3_q[F+1:0])) * P6W'(K06S);

  logic signed [NxW-1:0]  nx4_q;
  logic signed [NyW-1:0]  ny4_q;
  logic signed [RvxW-1:0] nvx4_q;
  logic signed [NvW-1:0]  nvy4_q;
  logic signed [P6W-1:0]  p06_4_q;
  logic                   s06_4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      nx4_q   <= nx3_q;
      ny4_q   <= NyW'(py3_q) + NyW'(ry3_q);
      nvx4_q  <= zx ? '0 : nvx3_q;
      nvy4_q  <= zy ? '0 : nvy3_q;
      p06_4_q <= p06;
      s06_4_q <= s06;
    end
  end

  // Stage 5: finish the slow-down, saturate into the output register
  logic signed [P6W:0]   r6s;
  logic signed [R6W-1:0] r6;
  logic signed [63:0]    nvy5;

  assign r6s  = (P6W+1)'(p06_4_q) + ((P6W+1)'(1) <<< (F - 1));
  assign r6   = R6W'(r6s >>> F);
  assign nvy5 = s06_4_q ? 64'(r6) : 64'(nvy4_q);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      out_word_o.new_pos_x <= sat32(64'(nx4_q));
      out_word_o.new_pos_y <= sat32(64'(ny4_q));
      out_word_o.new_vel_x <= sat32(64'(nvx4_q));
      out_word_o.new_vel_y <= sat32(nvy5);
    end
  end

  `CWB_ASSERT(a_vx_rest_band,
              out_valid_o && gpos_i |-> out_word_o.new_vel_x == '0 ||
              out_word_o.new_vel_x >= K01S || out_word_o.new_vel_x <= -K01S,
              "x velocity left inside rest band")

endmodule

### hw/rtl/circle_wall_bounce_and_integrate.sv
// Top level: configuration registers, wall clamp and integrator pipelines.
//
//  channel  direction  handshake                 word
//  in       to block   in_valid_i / in_ready_o   in_word_i   (cwbi_pkg::in_word_t)
//  out      from block out_valid_o / out_ready_i out_word_o  (cwbi_pkg::out_word_t)
//  cfg      to block   cfg_we_i, no wait         cfg_idx_i, cfg_data_i
//
// One word per cycle enters unless stalled; a result passes 4 wall stages, 5 integrate.
// The stage count is set by the two dependent multiply and round steps of the y update.
// Reset loads the register defaults and empties the pipeline; no clearing pass.
// A stage holds while the one after it is full and stalled; empty stages close up.
// Writes reach the drag term via drag_q, keep_q; the half gravity step via hgp_q, hg_q.
`include "circle_wall_bounce_and_integrate_macros.svh"

module circle_wall_bounce_and_integrate #(
  parameter int FRAC_BITS = cwbi_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cwbi_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cwbi_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cwbi_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cwbi_pkg::out_word_t             out_word_o
);

  localparam int F    = FRAC_BITS;
  localparam int PosW = cwbi_pkg::pos_w(F);
  localparam int VelW = cwbi_pkg::VelW;
  localparam int HgW  = cwbi_pkg::hg_w(F);
  localparam int DW   = cwbi_pkg::max_i(17, F + 1);

  localparam logic [DW-1:0] OneD = DW'(1) << F;

  logic [15:0]        field_width_q, field_height_q;
  logic [19:0]        time_step_q;
  logic signed [20:0] gravity_q;
  logic [16:0]        drag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q  <= cwbi_pkg::FieldWidthRst;
      field_height_q <= cwbi_pkg::FieldHeightRst;
      time_step_q    <= cwbi_pkg::TimeStepRst;
      gravity_q      <= '0;
      drag_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cwbi_pkg::CfgFieldWidth:  field_width_q  <= cfg_data_i[15:0];
        cwbi_pkg::CfgFieldHeight: field_height_q <= cfg_data_i[15:0];
        cwbi_pkg::CfgTimeStep:    time_step_q    <= cfg_data_i[19:0];
        cwbi_pkg::CfgGravity:     gravity_q      <= $signed(cfg_data_i[20:0]);
        cwbi_pkg::CfgDrag:        drag_q         <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Derived terms: drag clamped to one, half gravity step
  logic              gpos;
  logic [DW-1:0]     drag_ext;
  logic [F:0]        keep_d, keep_q;
  logic signed [41:0] hgp_d, hgp_q;
  logic signed [42:0] hgs;
  logic signed [HgW-1:0] hg_d, hg_q;

  assign gpos     = !gravity_q[20] && (gravity_q != '0);
  assign drag_ext = DW'(drag_q);
  assign keep_d   = (F+1)'((drag_ext > OneD) ? '0 : (OneD - drag_ext));
  assign hgp_d    = 42'($signed({1'b0, time_step_q})) * 42'(gravity_q);
  assign hgs      = 43'(hgp_q) + (43'(1) <<< F);
  assign hg_d     = HgW'(hgs >>> (F + 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= (F+1)'(OneD);
      hgp_q  <= '0;
      hg_q   <= '0;
    end else begin
      keep_q <= keep_d;
      hgp_q  <= hgp_d;
      hg_q   <= hg_d;
    end
  end

  logic                   mid_valid, mid_ready;
  logic signed [PosW-1:0] mid_px, mid_py;
  logic signed [VelW-1:0] mid_vx, mid_vy;

  cwbi_wall #(
    .FRAC_BITS(FRAC_BITS)
  ) u_wall (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .field_width_i  (field_width_q),
    .field_height_i (field_height_q),
    .gpos_i         (gpos),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_word_i      (in_word_i),
    .out_valid_o    (mid_valid),
    .out_ready_i    (mid_ready),
    .px_o           (mid_px),
    .py_o           (mid_py),
    .vx_o           (mid_vx),
    .vy_o           (mid_vy)
  );

  cwbi_integ #(
    .FRAC_BITS(FRAC_BITS)
  ) u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gpos_i      (gpos),
    .hg_i        (hg_q),
    .dt_i        (time_step_q),
    .keep_i      (keep_q),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .px_i        (mid_px),
    .py_i        (mid_py),
    .vx_i        (mid_vx),
    .vy_i        (mid_vy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  `CWB_ASSERT(a_gravity_write,
              cfg_we_i && cfg_idx_i == cwbi_pkg::CfgGravity |=>
              gravity_q == $past($signed(cfg_data_i[20:0])),
              "gravity write not taken")
  `CWB_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule
